### src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### src/phtk_pkg.sv
`timescale 1ns / 1ps
package phtk_pkg;

    localparam int unsigned OP_ADD    = 0;
    localparam int unsigned OP_REPORT = 1;

    localparam int unsigned IN_PORT_W  = 16;
    localparam int unsigned DELTA_W    = 32;
    localparam int unsigned RANK_W     = 4;
    localparam int unsigned OUT_PORT_W = 16;
    localparam int unsigned OUT_CNT_W  = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_UPDATE,
        ST_TRACK,
        ST_REPORT
    } back_state_t;

endpackage

### src/phtk_ram.sv
`timescale 1ns / 1ps
module phtk_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/phtk_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module phtk_front #(
    parameter int unsigned PORT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [phtk_pkg::IN_PORT_W-1:0]    s_port,
    input  logic [phtk_pkg::DELTA_W-1:0]      s_delta,
    output logic                              q_valid,
    input  logic                              q_ready,
    output logic                              q_op,
    output logic [PORT_BITS-1:0]              q_port,
    output logic [phtk_pkg::DELTA_W-1:0]      q_delta
);
    import phtk_pkg::*;

    localparam int unsigned QW = 1 + PORT_BITS + DELTA_W;

    logic [QW-1:0] q_mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;
    assign {q_op, q_port, q_delta} = q_mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wp_reg] <= {s_op, s_port[PORT_BITS-1:0], s_delta};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    `ASSERT_IMPL(a_no_overflow, clk, rst_n, cnt_reg == 2'd2, !push, "queue overflow")
    `ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3, "queue count out of range")

endmodule

### src/phtk_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module phtk_back #(
    parameter int unsigned TOP_ENTRIES = 10,
    parameter int unsigned PORT_BITS   = 16,
    parameter int unsigned COUNT_BITS  = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  logic                              q_op,
    input  logic [PORT_BITS-1:0]              q_port,
    input  logic [phtk_pkg::DELTA_W-1:0]      q_delta,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [phtk_pkg::RANK_W-1:0]       m_rank,
    output logic [phtk_pkg::OUT_PORT_W-1:0]   m_port,
    output logic [phtk_pkg::OUT_CNT_W-1:0]    m_count,
    output logic [phtk_pkg::OUT_CNT_W-1:0]    m_total,
    output logic                              m_entry_valid,
    output logic                              m_last
);
    import phtk_pkg::*;

    localparam int unsigned SPAN = 1 << PORT_BITS;
    localparam int unsigned FW   = $clog2(TOP_ENTRIES + 1);
    localparam int unsigned IW   = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1;
    localparam int unsigned SW   = COUNT_BITS + DELTA_W;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    back_state_t state_reg, state_next;

    logic [PORT_BITS-1:0]  clr_reg;
    logic [PORT_BITS-1:0]  port_reg;
    logic [DELTA_W-1:0]    delta_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [FW-1:0]         fill_reg;
    logic [FW-1:0]         ridx_reg;
    logic [PORT_BITS-1:0]  tp_reg [TOP_ENTRIES];
    logic [COUNT_BITS-1:0] tc_reg [TOP_ENTRIES];

    logic                  ram_we;
    logic [PORT_BITS-1:0]  ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [PORT_BITS-1:0]  ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;

    logic [SW-1:0]         sum_c, sum_t;
    logic [COUNT_BITS-1:0] new_cnt, new_tot;

    logic [TOP_ENTRIES-1:0] hit, ahd;
    logic                   found, full_fit;
    logic [IW-1:0]          hit_idx;
    logic [FW-1:0]          cand_pos;
    logic [FW-1:0]          src_pos;
    logic [FW-1:0]          fill_new;

    phtk_ram #(.WIDTH(COUNT_BITS), .DEPTH(SPAN)) u_cnt_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // hold the read on the captured port until the write
    assign ram_raddr = (state_reg == ST_IDLE) ? q_port : port_reg;

    assign sum_c   = SW'(ram_rdata) + SW'(delta_reg);
    assign sum_t   = SW'(total_reg) + SW'(delta_reg);
    assign new_cnt = (|sum_c[SW-1:COUNT_BITS]) ? CMAX : sum_c[COUNT_BITS-1:0];
    assign new_tot = (|sum_t[SW-1:COUNT_BITS]) ? CMAX : sum_t[COUNT_BITS-1:0];

    always_comb
    begin
        hit     = '0;
        ahd     = '0;
        hit_idx = '0;
        for (int i = 0; i < TOP_ENTRIES; i++)
        begin
            hit[i] = (FW'(i) < fill_reg) && (tp_reg[i] == port_reg);
            ahd[i] = (FW'(i) < fill_reg) && !hit[i] &&
                     ((cnt_reg > tc_reg[i]) ||
                      ((cnt_reg == tc_reg[i]) && (port_reg < tp_reg[i])));
        end
        for (int i = 0; i < TOP_ENTRIES; i++)
        begin
            if (hit[i])
            begin
                hit_idx = IW'(i);
            end
        end
        found    = |hit;
        cand_pos = FW'(TOP_ENTRIES);
        for (int i = TOP_ENTRIES - 1; i >= 0; i--)
        begin
            if (ahd[i])
            begin
                cand_pos = FW'(i);
            end
        end
        if (cand_pos == FW'(TOP_ENTRIES) && !found && fill_reg != FW'(TOP_ENTRIES))
        begin
            cand_pos = fill_reg;
        end
        if (found && cand_pos > FW'(hit_idx))
        begin
            cand_pos = FW'(hit_idx);
        end
        src_pos  = found ? FW'(hit_idx) :
                   (fill_reg != FW'(TOP_ENTRIES)) ? fill_reg : FW'(TOP_ENTRIES - 1);
        full_fit = found || (fill_reg != FW'(TOP_ENTRIES)) || (cand_pos != FW'(TOP_ENTRIES));
        fill_new = (!found && fill_reg != FW'(TOP_ENTRIES)) ? fill_reg + 1'b1 : fill_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_op == OP_REPORT[0]) ? ST_REPORT : ST_READ;
                end
            end
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_TRACK;
            ST_TRACK:  state_next = ST_IDLE;
            ST_REPORT:
            begin
                if (m_ready && m_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready   = (state_reg == ST_IDLE);
        ram_we    = 1'b0;
        ram_waddr = port_reg;
        ram_wdata = new_cnt;
        m_valid   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_UPDATE: ram_we  = 1'b1;
            ST_REPORT: m_valid = 1'b1;
            default:   ram_we  = 1'b0;
        endcase
    end

    always_comb
    begin
        m_rank        = RANK_W'(ridx_reg);
        m_port        = '0;
        m_count       = '0;
        m_total       = OUT_CNT_W'(total_reg);
        m_entry_valid = (fill_reg != '0);
        m_last        = (fill_reg == '0) || (ridx_reg + 1'b1 == fill_reg);
        if (fill_reg != '0)
        begin
            m_port  = OUT_PORT_W'(tp_reg[IW'(ridx_reg)]);
            m_count = OUT_CNT_W'(tc_reg[IW'(ridx_reg)]);
        end
        else
        begin
            m_rank = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            port_reg  <= q_port;
            delta_reg <= q_delta;
        end
        if (state_reg == ST_UPDATE)
        begin
            cnt_reg <= new_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            total_reg <= '0;
            fill_reg  <= '0;
            ridx_reg  <= '0;
            for (int i = 0; i < TOP_ENTRIES; i++)
            begin
                tp_reg[i] <= '0;
                tc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ST_UPDATE)
            begin
                total_reg <= new_tot;
            end
            if (state_reg == ST_TRACK && full_fit)
            begin
                // shift entries between the new place and the old one down by one
                for (int i = 0; i < TOP_ENTRIES; i++)
                begin
                    if (FW'(i) == cand_pos)
                    begin
                        tp_reg[i] <= port_reg;
                        tc_reg[i] <= cnt_reg;
                    end
                    else if (FW'(i) > cand_pos && FW'(i) <= src_pos && i > 0)
                    begin
                        tp_reg[i] <= tp_reg[i-1];
                        tc_reg[i] <= tc_reg[i-1];
                    end
                end
                fill_reg <= fill_new;
            end
            if (state_reg == ST_REPORT && m_ready)
            begin
                ridx_reg <= m_last ? '0 : ridx_reg + 1'b1;
            end
        end
    end

    `ASSERT_IMPL(a_fill_range, clk, rst_n, 1'b1, fill_reg <= FW'(TOP_ENTRIES), "fill beyond list")
    `ASSERT_NEXT(a_track_done, clk, rst_n, state_reg == ST_TRACK, state_reg == ST_IDLE,
        "track did not return to idle")
    `ASSERT_IMPL(a_ready_idle, clk, rst_n, q_ready, !m_valid, "report overlaps accept")

endmodule

### src/port_histogram_top_k_unit.sv
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit up)                 | tuser
// s_axis  | in  | port[15:0], delta[47:16]                  | operation
// m_axis  | out | rank[3:0], top_port[19:4], top_count[83:20],
//         |     | total_bytes[147:84], entry_valid[148], pad | tlast = last
// An increment passes through the back end in order: accept with counter read,
// read held, counter write, top-list update.
// A report is accepted, then gives one word per cycle while m_axis_tready is high.
// After reset all 2^PORT_BITS counter entries are cleared; the queue takes two words meanwhile.
// A two-word queue between front and back lets input be taken while a report stalls.
module port_histogram_top_k_unit #(
    parameter int unsigned TOP_ENTRIES = 10,
    parameter int unsigned PORT_BITS   = 16,
    parameter int unsigned COUNT_BITS  = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,  // port, delta
    input  logic         s_axis_tuser,  // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,  // rank, top_port, top_count, total_bytes, entry_valid
    output logic         m_axis_tlast   // last
);
    import phtk_pkg::*;

    logic                  q_valid, q_ready, q_op;
    logic [PORT_BITS-1:0]  q_port;
    logic [DELTA_W-1:0]    q_delta;
    logic [RANK_W-1:0]     rank;
    logic [OUT_PORT_W-1:0] top_port;
    logic [OUT_CNT_W-1:0]  top_count, total_bytes;
    logic                  entry_valid;

    phtk_front #(.PORT_BITS(PORT_BITS)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .s_valid(s_axis_tvalid),
        .s_ready(s_axis_tready),
        .s_op   (s_axis_tuser),
        .s_port (s_axis_tdata[15:0]),
        .s_delta(s_axis_tdata[47:16]),
        .q_valid(q_valid),
        .q_ready(q_ready),
        .q_op   (q_op),
        .q_port (q_port),
        .q_delta(q_delta)
    );

    phtk_back #(
        .TOP_ENTRIES(TOP_ENTRIES),
        .PORT_BITS  (PORT_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_op         (q_op),
        .q_port       (q_port),
        .q_delta      (q_delta),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .m_rank       (rank),
        .m_port       (top_port),
        .m_count      (top_count),
        .m_total      (total_bytes),
        .m_entry_valid(entry_valid),
        .m_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, entry_valid, total_bytes, top_count, top_port, rank};

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import phtk_pkg::*;

    typedef struct packed {
        logic [3:0]  rank;
        logic [15:0] top_port;
        logic [63:0] top_count;
        logic [63:0] total_bytes;
        logic        entry_valid;
        logic        last;
    } report_word_t;

    typedef struct {
        logic [15:0] port;
        logic [63:0] count;
    } hitter_t;

    localparam int TOP_N = 10;
    localparam logic [63:0] CNT_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int IDLE_LIMIT = 200000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [151:0] m_axis_tdata;
    logic         m_axis_tlast;

    port_histogram_top_k_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #5 clk = ~clk;

    logic [63:0]  port_bytes [logic [15:0]];
    logic [63:0]  bytes_total = '0;
    hitter_t      leaders [TOP_N];
    int           leader_fill = 0;
    report_word_t pending_words [$];

    int  mismatches = 0;
    int  words_seen = 0;
    int  reports_sent = 0;
    int  adds_sent = 0;
    int  idle_cycles = 0;
    bit  hold_sink = 1'b0;
    bit  burst_sink = 1'b0;

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] d);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, d};
        return s[64] ? CNT_MAX : s[63:0];
    endfunction

    function automatic bit outranks(hitter_t a, hitter_t b);
        if (a.count != b.count)
            return a.count > b.count;
        return a.port < b.port;
    endfunction

    function automatic void promote(int i);
        hitter_t t;
        while (i > 0 && outranks(leaders[i], leaders[i-1]))
        begin
            t = leaders[i];
            leaders[i] = leaders[i-1];
            leaders[i-1] = t;
            i--;
        end
    endfunction

    function automatic void tally(logic [15:0] port, logic [31:0] delta);
        hitter_t cand;
        logic [63:0] c;
        c = port_bytes.exists(port) ? port_bytes[port] : 64'd0;
        c = sat_sum(c, {32'd0, delta});
        port_bytes[port] = c;
        bytes_total = sat_sum(bytes_total, {32'd0, delta});
        for (int i = 0; i < leader_fill; i++)
        begin
            if (leaders[i].port == port)
            begin
                leaders[i].count = c;
                promote(i);
                return;
            end
        end
        cand.port = port;
        cand.count = c;
        if (leader_fill < TOP_N)
        begin
            leaders[leader_fill] = cand;
            leader_fill++;
            promote(leader_fill - 1);
        end
        else if (outranks(cand, leaders[TOP_N-1]))
        begin
            leaders[TOP_N-1] = cand;
            promote(TOP_N - 1);
        end
    endfunction

    function automatic void predict_report();
        report_word_t w;
        if (leader_fill == 0)
        begin
            w = '0;
            w.total_bytes = bytes_total;
            w.last = 1'b1;
            pending_words.insert(pending_words.size(), w);
            return;
        end
        for (int i = 0; i < leader_fill; i++)
        begin
            w.rank = i[3:0];
            w.top_port = leaders[i].port;
            w.top_count = leaders[i].count;
            w.total_bytes = bytes_total;
            w.entry_valid = 1'b1;
            w.last = (i + 1 == leader_fill);
            pending_words.insert(pending_words.size(), w);
        end
    endfunction

    task automatic random_gap(int chance);
        int n;
        if ($urandom_range(99) < chance)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_word(bit op, logic [15:0] port, logic [31:0] delta, int gap = 30);
        random_gap(gap);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {delta, port};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (op == OP_REPORT[0])
        begin
            predict_report();
            reports_sent++;
        end
        else
        begin
            tally(port, delta);
            adds_sent++;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_sink)
            m_axis_tready <= 1'b0;
        else if (burst_sink)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) < 70);
    end

    always @(posedge clk)
    begin
        report_word_t got;
        report_word_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("watchdog expired with %0d words pending", pending_words.size());
                $display("tb_top: FAIL");
                $finish;
            end
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_seen++;
            got.rank = m_axis_tdata[3:0];
            got.top_port = m_axis_tdata[19:4];
            got.top_count = m_axis_tdata[83:20];
            got.total_bytes = m_axis_tdata[147:84];
            got.entry_valid = m_axis_tdata[148];
            got.last = m_axis_tlast;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %p", got);
            end
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    task automatic test_empty_report();
        send_word(OP_REPORT[0], 16'hFFFF, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_directed();
        send_word(OP_ADD[0], 16'h0000, 32'd0);
        send_word(OP_REPORT[0], 16'h1234, 32'd5);
        send_word(OP_ADD[0], 16'hFFFF, 32'hFFFF_FFFF);
        send_word(OP_ADD[0], 16'h0001, 32'd7);
        send_word(OP_ADD[0], 16'h0002, 32'd7);
        send_word(OP_ADD[0], 16'h0001, 32'd0);
        for (int i = 0; i < 10; i++)
            send_word(OP_ADD[0], 16'h0100 + i[15:0], 32'd100 + i[31:0]);
        send_word(OP_ADD[0], 16'h0002, 32'd1000);
        send_word(OP_REPORT[0], 16'h0, 32'h0);
        drain();
    endtask

    task automatic test_large_deltas();
        repeat (5)
            send_word(OP_ADD[0], 16'hFFFF, 32'hFFFF_FFFF, 0);
        send_word(OP_REPORT[0], 16'h0, 32'h0);
        drain();
    endtask

    task automatic test_random(int n);
        logic [15:0] p;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 12)
                send_word(OP_REPORT[0], 16'($urandom()), $urandom());
            else
            begin
                p = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(24));
                send_word(OP_ADD[0], p,
                    ($urandom_range(4) == 0) ? $urandom() : $urandom_range(2000));
            end
        end
        send_word(OP_REPORT[0], 16'h0, 32'h0);
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_sink = 1'b1;
                repeat (300) @(negedge clk);
                hold_sink = 1'b0;
            end
            begin
                repeat (6)
                begin
                    send_word(OP_ADD[0], 16'($urandom_range(12)), $urandom_range(500), 0);
                    send_word(OP_REPORT[0], 16'h0, 32'h0, 0);
                end
            end
        join
        drain();
        burst_sink = 1'b1;
        repeat (8)
            send_word(OP_REPORT[0], 16'h0, 32'h0, 0);
        drain();
        burst_sink = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_report();
        test_directed();
        test_large_deltas();
        test_random(140);
        drain();
        test_backpressure();
        test_random(130);
        drain();
        $display("sent %0d increments and %0d reports, checked %0d report words",
            adds_sent, reports_sent, words_seen);
        $display("covered empty table, ties, zero deltas, large deltas and stalled output");
        if (mismatches == 0 && pending_words.size() == 0)
            $display("tb_top: PASS");
        else
        begin
            $display("%0d mismatches, %0d words missing", mismatches, pending_words.size());
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
